@@ hdl/vwbd_pkg.sv @@
// package: shared constants, codes and types of the volume window blob detector
`default_nettype none
package vwbd_pkg;

    localparam int VOL_D_DEF       = 64;
    localparam int VOL_H_DEF       = 128;
    localparam int VOL_W_DEF       = 128;
    localparam int WINDOW_DEF      = 9;
    localparam int CORE_RADIUS_DEF = 2;

    localparam int NUM_PLANES = 5;
    localparam int PLANE_SIDE = 5;
    localparam int MASK_W     = PLANE_SIDE * PLANE_SIDE;

    localparam logic [8:0] THRESHOLD_RST = 9'd128;
    localparam logic [9:0] MIN_FG_RST    = 10'd5;
    localparam logic [5:0] MARGIN_RST    = 6'd10;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_TEST = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_MIN_FG    = 2'd1;
    localparam logic [1:0] REG_MARGIN    = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_DECIDE = 6'b000100,
        S_MARK   = 6'b001000,
        S_RDWAIT = 6'b010000,
        S_EMIT   = 6'b100000
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctrl_t;

endpackage
`default_nettype wire

@@ hdl/vwbd_occ_mem.sv @@
// occupancy store: one row word per slice and row, bit write, registered row read
`default_nettype none
module vwbd_occ_mem
    import vwbd_pkg::*;
#(
    parameter int DEPTH = VOL_D_DEF * VOL_H_DEF,
    parameter int WIDTH = VOL_W_DEF
) (
    input  wire logic                       clk,
    input  wire mem_ctrl_t                  ctrl,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [$clog2(WIDTH)-1:0]   wr_col,
    input  wire logic                       wr_bit,
    output logic      [WIDTH-1:0]           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr][wr_col] <= wr_bit;
        end
        if (ctrl.rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ hdl/vwbd_mark_mem.sv @@
// mark store: row words, clearing pass after reset, registered row read
`default_nettype none
module vwbd_mark_mem
    import vwbd_pkg::*;
#(
    parameter int DEPTH = VOL_D_DEF * VOL_H_DEF,
    parameter int WIDTH = VOL_W_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire mem_ctrl_t                  ctrl,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [WIDTH-1:0]           wr_data,
    output logic      [WIDTH-1:0]           rd_data,
    output logic                            busy
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    clr_cnt_reg;
    logic [AW-1:0]    clr_cnt_next;
    logic             busy_reg;
    logic             busy_next;

    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        busy_next    = busy_reg;
        if (busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == AW'(DEPTH - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            busy_reg    <= 1'b1;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            busy_reg    <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (ctrl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

    assign busy = busy_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !ctrl.wr_en && !ctrl.rd_en)
        else $error("mark store accessed during clearing pass");

    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> $past(clr_cnt_reg) == AW'(DEPTH - 1))
        else $error("clearing pass ended early");

    assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |=> !busy_reg)
        else $error("clearing pass restarted without reset");

endmodule
`default_nettype wire

@@ hdl/volume_window_blob_detector.sv @@
// top level: configuration registers, test sequencer and result register
//
// channel  direction  transaction
// in       in         op, slice, row, col, intensity
// out      out        status, match, fg_count, plane, plane_mask, marked, last
// apb      in/out     threshold, min_fg, margin at byte address 4*index
//
// load: no result; read: mark row read when inside the volume, then one result
// test: one window row per cycle from the occupancy port over the whole window,
//   plus a mark read-modify-write of every window row on a match, then 5 results
// origin outside scan range: one result only
// after reset the mark store is cleared with in_stall high
// out_stall holds the current result; in_stall stays high until the last is taken
`default_nettype none
module volume_window_blob_detector
    import vwbd_pkg::*;
#(
    parameter int VOL_D       = VOL_D_DEF,
    parameter int VOL_H       = VOL_H_DEF,
    parameter int VOL_W       = VOL_W_DEF,
    parameter int WINDOW      = WINDOW_DEF,
    parameter int CORE_RADIUS = CORE_RADIUS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  op,
    input  wire logic [5:0]  slice,
    input  wire logic [6:0]  row,
    input  wire logic [6:0]  col,
    input  wire logic [7:0]  intensity,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             status,
    output logic             match,
    output logic [9:0]       fg_count,
    output logic [2:0]       plane,
    output logic [24:0]      plane_mask,
    output logic             marked,
    output logic             last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int DEPTH   = VOL_D * VOL_H;
    localparam int AW      = $clog2(DEPTH);
    localparam int CIW     = $clog2(VOL_W);
    localparam int WIW     = $clog2(WINDOW);
    localparam int CW      = $clog2(WINDOW * WINDOW * WINDOW + 1);
    localparam int MW      = (CW > 10) ? CW : 10;
    localparam int LO_RAW  = WINDOW / 2 - CORE_RADIUS;
    localparam int HI_RAW  = WINDOW / 2 + CORE_RADIUS;
    localparam int LO      = (LO_RAW < 0) ? 0 : LO_RAW;
    localparam int HI      = (HI_RAW > WINDOW - 1) ? WINDOW - 1 : HI_RAW;
    localparam logic [WINDOW-1:0] COL_CORE =
        WINDOW'(((64'd1 << (HI + 1)) - 64'd1) & ~((64'd1 << LO) - 64'd1));
    localparam logic [AW-1:0] SLICE_STEP = AW'(VOL_H - (WINDOW - 1));

    state_t            state_reg, state_next;
    logic [8:0]        threshold_reg;
    logic [9:0]        min_fg_reg;
    logic [5:0]        margin_reg;
    logic [6:0]        col_reg, col_next;
    logic [AW-1:0]     base_reg, base_next;
    logic [AW-1:0]     cur_addr_reg, cur_addr_next;
    logic [AW-1:0]     addr_d_reg, addr_d_next;
    logic [WIW-1:0]    a_reg, a_next, b_reg, b_next;
    logic [WIW-1:0]    ad_reg, ad_next, bd_reg, bd_next;
    logic              iss_reg, iss_next;
    logic              pv_reg, pv_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              outside_reg, outside_next;
    logic [MASK_W-1:0] mask_reg [NUM_PLANES];
    logic [MASK_W-1:0] mask_next [NUM_PLANES];
    logic              out_valid_reg, out_valid_next;
    logic              status_reg, status_next;
    logic              match_reg, match_next;
    logic              marked_reg, marked_next;
    logic              test_out_reg, test_out_next;
    logic [2:0]        plane_reg, plane_next;

    mem_ctrl_t         occ_ctrl, mark_ctrl;
    logic [AW-1:0]     occ_rd_addr, mark_rd_addr;
    logic [VOL_W-1:0]  occ_rdata, mark_rdata, mark_wdata, win_shift;
    logic              clear_busy;

    logic              accept_in, accept_out, cfg_wr;
    logic              in_vol, in_range;
    logic [AW-1:0]     in_base;
    logic [WINDOW-1:0] w;
    logic [WINDOW+4:0] wpad;
    logic [CW-1:0]     pop;
    logic              row_core, row_out;
    logic              row_last;

    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite;
    assign in_stall   = (state_reg != S_IDLE) || clear_busy;
    assign accept_in  = in_valid && !in_stall;
    assign accept_out = out_valid_reg && !out_stall;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_THRESHOLD: prdata = 32'(threshold_reg);
            REG_MIN_FG:    prdata = 32'(min_fg_reg);
            REG_MARGIN:    prdata = 32'(margin_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RST;
            min_fg_reg    <= MIN_FG_RST;
            margin_reg    <= MARGIN_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_THRESHOLD: threshold_reg <= pwdata[8:0];
                REG_MIN_FG:    min_fg_reg    <= pwdata[9:0];
                REG_MARGIN:    margin_reg    <= pwdata[5:0];
                default:       ;
            endcase
        end
    end

    assign in_vol = (int'(slice) < VOL_D) && (int'(row) < VOL_H) && (int'(col) < VOL_W);
    assign in_range = (int'(slice) < VOL_D - WINDOW) &&
                      (int'(row) >= int'(margin_reg)) &&
                      (int'(row) < VOL_H - WINDOW - int'(margin_reg)) &&
                      (int'(col) >= int'(margin_reg)) &&
                      (int'(col) < VOL_W - WINDOW - int'(margin_reg));
    assign in_base = AW'(int'(slice) * VOL_H + int'(row));

    // window row currently returned by the occupancy store
    assign w        = WINDOW'(occ_rdata >> col_reg);
    assign wpad     = {5'b0, w};
    assign row_core = (int'(ad_reg) >= LO) && (int'(ad_reg) <= HI) &&
                      (int'(bd_reg) >= LO) && (int'(bd_reg) <= HI);
    assign row_out  = row_core ? |(w & ~COL_CORE) : |w;
    assign row_last = (ad_reg == WIW'(WINDOW - 1)) && (bd_reg == WIW'(WINDOW - 1));
    assign win_shift  = VOL_W'({WINDOW{1'b1}}) << col_reg;
    assign mark_wdata = (mark_rdata & ~win_shift) | (occ_rdata & win_shift);

    always_comb
    begin
        pop = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            pop = pop + CW'(w[i]);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        base_next      = base_reg;
        cur_addr_next  = cur_addr_reg;
        addr_d_next    = cur_addr_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        ad_next        = a_reg;
        bd_next        = b_reg;
        iss_next       = iss_reg;
        pv_next        = 1'b0;
        cnt_next       = cnt_reg;
        outside_next   = outside_reg;
        mask_next      = mask_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        match_next     = match_reg;
        marked_next    = marked_reg;
        test_out_next  = test_out_reg;
        plane_next     = plane_reg;
        occ_ctrl       = '0;
        mark_ctrl      = '0;
        occ_rd_addr    = cur_addr_reg;
        mark_rd_addr   = cur_addr_reg;

        occ_ctrl.wr_en = accept_in && op == OP_LOAD && in_vol;

        // window row address walk
        if ((state_reg == S_SCAN || state_reg == S_MARK) && iss_reg)
        begin
            occ_ctrl.rd_en = 1'b1;
            pv_next        = 1'b1;
            if (b_reg == WIW'(WINDOW - 1))
            begin
                b_next        = '0;
                a_next        = a_reg + 1'b1;
                cur_addr_next = cur_addr_reg + SLICE_STEP;
                if (a_reg == WIW'(WINDOW - 1))
                begin
                    iss_next = 1'b0;
                end
            end
            else
            begin
                b_next        = b_reg + 1'b1;
                cur_addr_next = cur_addr_reg + 1'b1;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept_in && op == OP_READ)
                begin
                    col_next      = col;
                    status_next   = 1'b0;
                    match_next    = 1'b0;
                    marked_next   = 1'b0;
                    test_out_next = 1'b0;
                    plane_next    = '0;
                    if (in_vol)
                    begin
                        mark_ctrl.rd_en = 1'b1;
                        mark_rd_addr    = in_base;
                        state_next      = S_RDWAIT;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        state_next     = S_EMIT;
                    end
                end
                else if (accept_in && op == OP_TEST)
                begin
                    status_next   = !in_range;
                    match_next    = 1'b0;
                    marked_next   = 1'b0;
                    test_out_next = 1'b0;
                    plane_next    = '0;
                    col_next      = col;
                    base_next     = in_base;
                    cur_addr_next = in_base;
                    a_next        = '0;
                    b_next        = '0;
                    cnt_next      = '0;
                    outside_next  = 1'b0;
                    for (int p = 0; p < NUM_PLANES; p++)
                    begin
                        mask_next[p] = '0;
                    end
                    if (in_range)
                    begin
                        iss_next   = 1'b1;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        state_next     = S_EMIT;
                    end
                end
            end
            S_SCAN:
            begin
                if (pv_reg)
                begin
                    cnt_next     = cnt_reg + pop;
                    outside_next = outside_reg | row_out;
                    for (int p = 0; p < NUM_PLANES; p++)
                    begin
                        for (int i = 0; i < PLANE_SIDE; i++)
                        begin
                            if ((LO + p <= HI) && (LO + i <= HI) &&
                                (int'(ad_reg) == LO + p) && (int'(bd_reg) == LO + i))
                            begin
                                for (int j = 0; j < PLANE_SIDE; j++)
                                begin
                                    mask_next[p][i * PLANE_SIDE + j] =
                                        (LO + j <= HI) ? wpad[LO + j] : 1'b0;
                                end
                            end
                        end
                    end
                    if (row_last)
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE:
            begin
                test_out_next = 1'b1;
                match_next = (MW'(cnt_reg) >= MW'(min_fg_reg)) && !outside_reg;
                if ((MW'(cnt_reg) >= MW'(min_fg_reg)) && !outside_reg)
                begin
                    cur_addr_next = base_reg;
                    a_next        = '0;
                    b_next        = '0;
                    iss_next      = 1'b1;
                    state_next    = S_MARK;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_EMIT;
                end
            end
            S_MARK:
            begin
                mark_ctrl.rd_en = iss_reg;
                if (pv_reg)
                begin
                    mark_ctrl.wr_en = 1'b1;
                    if (row_last)
                    begin
                        out_valid_next = 1'b1;
                        state_next     = S_EMIT;
                    end
                end
            end
            S_RDWAIT:
            begin
                marked_next    = 1'(mark_rdata >> col_reg);
                out_valid_next = 1'b1;
                state_next     = S_EMIT;
            end
            S_EMIT:
            begin
                if (accept_out)
                begin
                    if (last)
                    begin
                        out_valid_next = 1'b0;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        plane_next = plane_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iss_reg       <= 1'b0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iss_reg       <= iss_next;
            pv_reg        <= pv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg      <= col_next;
        base_reg     <= base_next;
        cur_addr_reg <= cur_addr_next;
        addr_d_reg   <= addr_d_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        ad_reg       <= ad_next;
        bd_reg       <= bd_next;
        cnt_reg      <= cnt_next;
        outside_reg  <= outside_next;
        mask_reg     <= mask_next;
        status_reg   <= status_next;
        match_reg    <= match_next;
        marked_reg   <= marked_next;
        test_out_reg <= test_out_next;
        plane_reg    <= plane_next;
    end

    vwbd_occ_mem #(
        .DEPTH (DEPTH),
        .WIDTH (VOL_W)
    ) u_occ (
        .clk     (clk),
        .ctrl    (occ_ctrl),
        .rd_addr (occ_rd_addr),
        .wr_addr (in_base),
        .wr_col  (CIW'(col)),
        .wr_bit  ({1'b0, intensity} >= threshold_reg),
        .rd_data (occ_rdata)
    );

    vwbd_mark_mem #(
        .DEPTH (DEPTH),
        .WIDTH (VOL_W)
    ) u_mark (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mark_ctrl),
        .rd_addr (mark_rd_addr),
        .wr_addr (addr_d_reg),
        .wr_data (mark_wdata),
        .rd_data (mark_rdata),
        .busy    (clear_busy)
    );

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign match      = test_out_reg && match_reg;
    assign fg_count   = test_out_reg ? 10'(cnt_reg) : 10'd0;
    assign plane      = plane_reg;
    assign plane_mask = test_out_reg ? mask_reg[plane_reg] : '0;
    assign marked     = marked_reg;
    assign last       = !test_out_reg || (plane_reg == 3'(NUM_PLANES - 1));

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == S_EMIT)
        else $error("result shown outside emit state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept_out && last) |=> !out_valid_reg && state_reg == S_IDLE)
        else $error("results continue after last");

    assert property (@(posedge clk) disable iff (!rst_n)
        mark_ctrl.wr_en |-> state_reg == S_MARK && match_reg)
        else $error("mark write without a matched window");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> plane_reg < 3'(NUM_PLANES))
        else $error("plane index out of range");

endmodule
`default_nettype wire

@@ dv/tb_volume_window_blob_detector.sv @@
// testbench for the volume window blob detector: directed table, then randomised phases
`timescale 1ns / 100ps
module tb_volume_window_blob_detector;
    import vwbd_pkg::*;

    localparam int NVOX     = 1 << 20;
    localparam int WIN      = 9;
    localparam int CORE_LO  = WIN / 2 - CORE_RADIUS_DEF;
    localparam int CORE_HI  = WIN / 2 + CORE_RADIUS_DEF;
    localparam int RB_S     = 20;
    localparam int RB_R     = 30;
    localparam int RB_C     = 30;
    localparam int RB_SIZE  = 10;
    localparam int STALL_LIMIT = 30000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic        status;
        logic        match;
        logic [9:0]  fg_count;
        logic [2:0]  plane;
        logic [24:0] plane_mask;
        logic        marked;
        logic        last;
    } result_t;

    typedef struct {
        logic [1:0] op;
        logic [5:0] s;
        logic [6:0] r;
        logic [6:0] c;
        logic [7:0] v;
        bit         typed;
        result_t    res;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  op;
    logic [5:0]  slice;
    logic [6:0]  row;
    logic [6:0]  col;
    logic [7:0]  intensity;
    logic        out_valid;
    logic        out_stall;
    logic        status;
    logic        match;
    logic [9:0]  fg_count;
    logic [2:0]  plane;
    logic [24:0] plane_mask;
    logic        marked;
    logic        last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    volume_window_blob_detector uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .slice(slice), .row(row), .col(col), .intensity(intensity),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .match(match), .fg_count(fg_count), .plane(plane),
        .plane_mask(plane_mask), .marked(marked), .last(last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    bit occ_bits [NVOX];
    bit mark_bits [NVOX];
    bit loaded [NVOX];
    logic [8:0] thr_cfg;
    logic [9:0] min_fg_cfg;
    logic [5:0] margin_cfg;

    result_t pending_results [$];
    row_t    dir_rows [$];
    int      errors;
    int      idle_mode;
    int      quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int send_gap_pct();
        return (idle_mode == 1) ? 67 : (idle_mode == 3) ? 9 : 0;
    endfunction

    function automatic int recv_gap_pct();
        return (idle_mode == 2) ? 67 : (idle_mode == 3) ? 9 : 0;
    endfunction

    function automatic int vox(input int s, input int r, input int c);
        return (s << 14) | (r << 7) | c;
    endfunction

    function automatic result_t mk_res(input logic st, input logic mt, input logic [9:0] cnt,
                                       input logic [2:0] pl, input logic [24:0] msk,
                                       input logic mkd, input logic lst);
        result_t x;
        x.status = st;
        x.match = mt;
        x.fg_count = cnt;
        x.plane = pl;
        x.plane_mask = msk;
        x.marked = mkd;
        x.last = lst;
        return x;
    endfunction

    function automatic bit origin_in_range(input int s, input int r, input int c);
        int sh;
        int rh;
        int ch;
        sh = 64 - WIN;
        rh = 128 - WIN - margin_cfg;
        ch = 128 - WIN - margin_cfg;
        return (s < sh) && (r >= margin_cfg) && (r < rh) && (c >= margin_cfg) && (c < ch);
    endfunction

    function automatic bit window_loaded(input int s, input int r, input int c);
        for (int a = 0; a < WIN; a++)
            for (int b = 0; b < WIN; b++)
                for (int d = 0; d < WIN; d++)
                    if (!loaded[vox(s + a, r + b, c + d)])
                        return 1'b0;
        return 1'b1;
    endfunction

    task automatic predict_blob(input logic [1:0] o, input int s, input int r, input int c,
                                input int v);
        int cnt;
        int outside;
        bit hit;
        logic [24:0] msk;
        if (o == OP_LOAD)
        begin
            occ_bits[vox(s, r, c)] = (v >= thr_cfg);
            loaded[vox(s, r, c)] = 1'b1;
        end
        else if (o == OP_READ)
            pending_results.push_back(mk_res(0, 0, 0, 0, 0, mark_bits[vox(s, r, c)], 1));
        else if (o == OP_TEST)
        begin
            if (!origin_in_range(s, r, c))
                pending_results.push_back(mk_res(1, 0, 0, 0, 0, 0, 1));
            else
            begin
                cnt = 0;
                outside = 0;
                for (int a = 0; a < WIN; a++)
                    for (int b = 0; b < WIN; b++)
                        for (int d = 0; d < WIN; d++)
                            if (occ_bits[vox(s + a, r + b, c + d)])
                            begin
                                cnt++;
                                if (a < CORE_LO || a > CORE_HI || b < CORE_LO || b > CORE_HI
                                    || d < CORE_LO || d > CORE_HI)
                                    outside++;
                            end
                hit = (cnt >= min_fg_cfg) && (outside == 0);
                if (hit)
                    for (int a = 0; a < WIN; a++)
                        for (int b = 0; b < WIN; b++)
                            for (int d = 0; d < WIN; d++)
                                mark_bits[vox(s + a, r + b, c + d)] =
                                    occ_bits[vox(s + a, r + b, c + d)];
                for (int p = 0; p < NUM_PLANES; p++)
                begin
                    msk = '0;
                    for (int i = 0; i < PLANE_SIDE; i++)
                        for (int j = 0; j < PLANE_SIDE; j++)
                            if (occ_bits[vox(s + CORE_LO + p, r + CORE_LO + i,
                                             c + CORE_LO + j)])
                                msk[i * PLANE_SIDE + j] = 1'b1;
                    pending_results.push_back(mk_res(0, hit, cnt[9:0], p[2:0], msk, 0,
                                                     p == NUM_PLANES - 1));
                end
            end
        end
    endtask

    task automatic send_item(input logic [1:0] o, input int s, input int r, input int c,
                             input int v, input bit typed, input result_t res);
        while ($urandom_range(99) < send_gap_pct())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        slice <= s[5:0];
        row <= r[6:0];
        col <= c[6:0];
        intensity <= v[7:0];
        do
            @(posedge clk);
        while (in_stall);
        if (typed)
            pending_results.push_back(res);
        else
            predict_blob(o, s, r, c, v);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_THRESHOLD: thr_cfg = value[8:0];
            REG_MIN_FG:    min_fg_cfg = value[9:0];
            REG_MARGIN:    margin_cfg = value[5:0];
            default: ;
        endcase
    endtask

    task automatic add_row(input logic [1:0] o, input int s, input int r, input int c,
                           input int v, input bit typed, input result_t res);
        row_t x;
        x.op = o;
        x.s = s[5:0];
        x.r = r[6:0];
        x.c = c[6:0];
        x.v = v[7:0];
        x.typed = typed;
        x.res = res;
        dir_rows.push_back(x);
    endtask

    task automatic random_item();
        int k;
        int s;
        int r;
        int c;
        int v;
        int a;
        int b;
        int d;
        k = $urandom_range(99);
        if (k < 45)
        begin
            a = $urandom_range(RB_SIZE - 1);
            b = $urandom_range(RB_SIZE - 1);
            d = $urandom_range(RB_SIZE - 1);
            if (a >= 2 && a <= 7 && b >= 2 && b <= 7 && d >= 2 && d <= 7)
                v = ($urandom_range(1) != 0) ? $urandom_range(255) : 0;
            else
                v = ($urandom_range(9) == 0) ? $urandom_range(255) : 0;
            send_item(OP_LOAD, RB_S + a, RB_R + b, RB_C + d, v, 0, '0);
        end
        else if (k < 50)
            send_item(OP_LOAD, $urandom_range(63), $urandom_range(127), $urandom_range(127),
                      $urandom_range(255), 0, '0);
        else if (k < 75)
        begin
            s = RB_S + $urandom_range(1);
            r = RB_R + $urandom_range(1);
            c = RB_C + $urandom_range(1);
            if ($urandom_range(99) < 40)
            begin
                s = $urandom_range(63);
                r = $urandom_range(127);
                c = $urandom_range(127);
                if (origin_in_range(s, r, c) && !window_loaded(s, r, c))
                begin
                    s = RB_S;
                    r = RB_R;
                    c = RB_C;
                end
            end
            send_item(OP_TEST, s, r, c, $urandom_range(255), 0, '0);
        end
        else if (k < 95)
        begin
            if ($urandom_range(99) < 70)
                send_item(OP_READ, RB_S + $urandom_range(RB_SIZE - 1),
                          RB_R + $urandom_range(RB_SIZE - 1), RB_C + $urandom_range(RB_SIZE - 1),
                          $urandom_range(255), 0, '0);
            else
                send_item(OP_READ, $urandom_range(63), $urandom_range(127), $urandom_range(127),
                          $urandom_range(255), 0, '0);
        end
        else
            send_item(OP_UNUSED, $urandom_range(63), $urandom_range(127), $urandom_range(127),
                      $urandom_range(255), 0, '0);
    endtask

    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(99) < recv_gap_pct());

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected");
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, status);
                    errors++;
                end
                if (match !== want.match)
                begin
                    $error("match expected %0d actual %0d", want.match, match);
                    errors++;
                end
                if (fg_count !== want.fg_count)
                begin
                    $error("fg_count expected %0d actual %0d", want.fg_count, fg_count);
                    errors++;
                end
                if (plane !== want.plane)
                begin
                    $error("plane expected %0d actual %0d", want.plane, plane);
                    errors++;
                end
                if (plane_mask !== want.plane_mask)
                begin
                    $error("plane_mask expected %h actual %h", want.plane_mask, plane_mask);
                    errors++;
                end
                if (marked !== want.marked)
                begin
                    $error("marked expected %0d actual %0d", want.marked, marked);
                    errors++;
                end
                if (last !== want.last)
                begin
                    $error("last expected %0d actual %0d", want.last, last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("volume_window_blob_detector verification failed");
            $finish;
        end
    end

    initial
    begin
        int thr_set [8];
        int min_set [8];
        int mar_set [8];
        thr_set = '{128, 0, 256, 200, 50, 128, 255, 100};
        min_set = '{5, 0, 729, 1, 3, 10, 2, 0};
        mar_set = '{10, 0, 63, 30, 5, 20, 1, 31};
        idle_mode = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_LOAD;
        slice = '0;
        row = '0;
        col = '0;
        intensity = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        thr_cfg = THRESHOLD_RST;
        min_fg_cfg = MIN_FG_RST;
        margin_cfg = MARGIN_RST;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // background fill of the test region
        for (int a = 0; a < RB_SIZE; a++)
            for (int b = 0; b < RB_SIZE; b++)
                for (int d = 0; d < RB_SIZE; d++)
                    send_item(OP_LOAD, RB_S + a, RB_R + b, RB_C + d, 0, 0, '0);

        add_row(OP_READ, RB_S, RB_R, RB_C, 0, 1, mk_res(0, 0, 0, 0, 0, 0, 1));
        add_row(OP_TEST, 55, RB_R, RB_C, 0, 1, mk_res(1, 0, 0, 0, 0, 0, 1));
        add_row(OP_TEST, RB_S, 9, RB_C, 0, 1, mk_res(1, 0, 0, 0, 0, 0, 1));
        add_row(OP_TEST, RB_S, 109, RB_C, 0, 1, mk_res(1, 0, 0, 0, 0, 0, 1));
        add_row(OP_TEST, RB_S, RB_R, 0, 0, 1, mk_res(1, 0, 0, 0, 0, 0, 1));
        add_row(OP_UNUSED, RB_S, RB_R, RB_C, 255, 0, '0);
        add_row(OP_TEST, RB_S, RB_R, RB_C, 0, 0, '0);
        add_row(OP_LOAD, 22, 32, 32, 255, 0, '0);
        add_row(OP_LOAD, 22, 32, 33, 127, 0, '0);
        add_row(OP_LOAD, 22, 32, 34, 128, 0, '0);
        add_row(OP_LOAD, 23, 33, 33, 255, 0, '0);
        add_row(OP_LOAD, 24, 34, 34, 200, 0, '0);
        add_row(OP_LOAD, 26, 36, 36, 255, 0, '0);
        add_row(OP_LOAD, 25, 35, 35, 129, 0, '0);
        add_row(OP_TEST, RB_S, RB_R, RB_C, 0, 0, '0);
        add_row(OP_READ, 22, 32, 32, 0, 0, '0);
        add_row(OP_READ, 22, 32, 33, 0, 0, '0);
        add_row(OP_LOAD, RB_S, RB_R, RB_C, 255, 0, '0);
        add_row(OP_TEST, RB_S, RB_R, RB_C, 0, 0, '0);
        add_row(OP_READ, 63, 127, 127, 255, 1, mk_res(0, 0, 0, 0, 0, 0, 1));
        add_row(OP_READ, 0, 0, 0, 0, 1, mk_res(0, 0, 0, 0, 0, 0, 1));
        add_row(OP_TEST, RB_S + 1, RB_R + 1, RB_C + 1, 0, 0, '0);
        add_row(OP_LOAD, RB_S, RB_R, RB_C, 0, 0, '0);
        foreach (dir_rows[i])
            send_item(dir_rows[i].op, dir_rows[i].s, dir_rows[i].r, dir_rows[i].c,
                      dir_rows[i].v, dir_rows[i].typed, dir_rows[i].res);
        drain_results();

        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(REG_THRESHOLD, thr_set[ph]);
            write_reg(REG_MIN_FG, min_set[ph]);
            write_reg(REG_MARGIN, mar_set[ph]);
            idle_mode = ph % 4;
            repeat (52) random_item();
            drain_results();
        end

        idle_mode = 0;
        repeat (200) @(negedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("volume_window_blob_detector verification clean");
        else
            $display("volume_window_blob_detector verification failed");
        $finish;
    end

endmodule
